/* hw/rtl/boxiou_pkg.sv */
// box overlap scorer: shared types, constants and the divider step
`timescale 1ns / 1ps
package boxiou_pkg;

  localparam int CW        = 13;   // coordinate and extent field width
  localparam int FW        = 25;   // frame area and overlap area width
  localparam int IW        = 30;   // intersection area width
  localparam int MW        = 64;   // product and ratio operand width
  localparam int QW        = 16;   // quotient bits, Q0.16
  localparam int ACCW      = 17;   // accuracy width
  localparam int DIV_STEPS = QW;

  localparam logic [ACCW-1:0] ACC_ONE  = 17'h10000;
  localparam logic [FW-1:0]   AREA_MAX = 25'h1FFFFFF;

  // register indexes of the configuration port
  localparam logic REG_UNBIASED = 1'b0;
  localparam logic REG_FRAME    = 1'b1;

  typedef struct packed {
    logic [MW-1:0] r;      // partial remainder
    logic [MW-1:0] d;      // divisor
    logic [QW-1:0] q;      // quotient so far
    logic          zero;   // score is 0
    logic          one;    // score is 1.0
    logic          flag;   // ratio undefined: union not positive, or zero background in unbiased mode
    logic [IW-1:0] inter;  // intersection area
  } div_t;

  // one restoring division step, one quotient bit
  function automatic div_t div_step(div_t s);
    div_t          o;
    logic [MW:0]   r2;
    logic [MW:0]   diff;
    o    = s;
    r2   = {s.r, 1'b0};
    diff = r2 - {1'b0, s.d};
    if (r2 >= {1'b0, s.d}) begin
      o.r = diff[MW-1:0];
      o.q = {s.q[QW-2:0], 1'b1};
    end else begin
      o.r = r2[MW-1:0];
      o.q = {s.q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* hw/rtl/box_overlap_iou_scorer_unit.sv */
// box overlap scorer top level: pipelined intersection over union with q16 divider
`timescale 1ns / 1ps
// Scores an annotation box against a detected box as plain IoU or background-weighted
// (unbiased) IoU in unsigned Q1.16, clamped to 0..1, and reports the intersection area.
// The datapath is a 22-stage pipeline: six stages of geometry, areas and products, then
// sixteen stages of a restoring divider, one quotient bit each. One box pair is taken
// every cycle while the output is not stalled; a stall at the output holds the whole
// pipeline. Configuration is taken any cycle and must only be written while no beat is
// in flight.
module box_overlap_iou_scorer_unit #(
  parameter int COORD_RANGE = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [boxiou_pkg::FW-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [boxiou_pkg::CW-1:0] annot_left,
  input  logic signed [boxiou_pkg::CW-1:0] annot_top,
  input  logic [boxiou_pkg::CW-1:0]       annot_width,
  input  logic [boxiou_pkg::CW-1:0]       annot_height,
  input  logic signed [boxiou_pkg::CW-1:0] det_left,
  input  logic signed [boxiou_pkg::CW-1:0] det_top,
  input  logic [boxiou_pkg::CW-1:0]       det_width,
  input  logic [boxiou_pkg::CW-1:0]       det_height,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [boxiou_pkg::ACCW-1:0]     accuracy,
  output logic [boxiou_pkg::FW-1:0]       overlap_area,
  output logic                            undefined_ratio
);
  import boxiou_pkg::*;

  localparam int NSTG = 6 + DIV_STEPS;

  logic          unbiased_mode;
  logic [FW-1:0] frame_area;
  logic [NSTG-1:0] vld;
  logic          adv;

  assign cfg_ready = 1'b1;
  assign adv       = !vld[NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      unbiased_mode <= 1'b1;
      frame_area    <= 25'd307200;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UNBIASED: unbiased_mode <= cfg_data[0];
        REG_FRAME:    frame_area    <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // stage 1: clamp extents, intersection edges
  function automatic logic [CW-1:0] clamp_ext(logic [CW-1:0] v);
    return (32'(v) > 32'(COORD_RANGE)) ? CW'(COORD_RANGE) : v;
  endfunction

  logic [CW-1:0]        aw_c, ah_c, dw_c, dh_c;
  logic signed [15:0]   ar_c, ab_c, dr_c, db_c;
  logic [CW-1:0]        s1_aw, s1_ah, s1_dw, s1_dh;
  logic signed [15:0]   s1_x0, s1_y0, s1_x1, s1_y1;

  always_comb begin
    aw_c = clamp_ext(annot_width);
    ah_c = clamp_ext(annot_height);
    dw_c = clamp_ext(det_width);
    dh_c = clamp_ext(det_height);
    ar_c = 16'(annot_left) + $signed({3'b0, aw_c});
    ab_c = 16'(annot_top)  + $signed({3'b0, ah_c});
    dr_c = 16'(det_left)   + $signed({3'b0, dw_c});
    db_c = 16'(det_top)    + $signed({3'b0, dh_c});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_aw <= aw_c;
      s1_ah <= ah_c;
      s1_dw <= dw_c;
      s1_dh <= dh_c;
      s1_x0 <= (annot_left > det_left) ? 16'(annot_left) : 16'(det_left);
      s1_y0 <= (annot_top > det_top) ? 16'(annot_top) : 16'(det_top);
      s1_x1 <= (ar_c < dr_c) ? ar_c : dr_c;
      s1_y1 <= (ab_c < db_c) ? ab_c : db_c;
    end
  end

  // stage 2: intersection size, box areas
  logic signed [15:0] iw_c, ih_c;
  logic [14:0]        s2_iw, s2_ih;
  logic               s2_ne;
  logic [25:0]        s2_aa, s2_da;

  assign iw_c = s1_x1 - s1_x0;
  assign ih_c = s1_y1 - s1_y0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_iw <= iw_c[14:0];
      s2_ih <= ih_c[14:0];
      s2_ne <= (iw_c > 16'sd0) && (ih_c > 16'sd0);
      s2_aa <= 26'(s1_aw) * 26'(s1_ah);
      s2_da <= 26'(s1_dw) * 26'(s1_dh);
    end
  end

  // stage 3: intersection area
  logic [IW-1:0] s3_inter;
  logic [25:0]   s3_aa, s3_da;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_inter <= s2_ne ? IW'(s2_iw) * IW'(s2_ih) : '0;
      s3_aa    <= s2_aa;
      s3_da    <= s2_da;
    end
  end

  // stage 4: union, background terms, undefined check
  logic signed [31:0] uni_c, bg_c, fu_c;
  logic signed [31:0] s4_uni, s4_bg, s4_fu;
  logic [IW-1:0]      s4_inter;
  logic               s4_flag;

  always_comb begin
    uni_c = $signed(32'(s3_aa)) + $signed(32'(s3_da)) - $signed(32'(s3_inter));
    bg_c  = $signed(32'(frame_area)) - $signed(32'(s3_inter));
    fu_c  = $signed(32'(frame_area)) - uni_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_uni   <= uni_c;
      s4_bg    <= bg_c;
      s4_fu    <= fu_c;
      s4_inter <= s3_inter;
      s4_flag  <= (uni_c <= 32'sd0) || (unbiased_mode && (bg_c == 32'sd0));
    end
  end

  // stage 5: products
  logic signed [MW-1:0] s5_ui, s5_bf, s5_uu, s5_bb;
  logic signed [31:0]   s5_uni;
  logic [IW-1:0]        s5_inter;
  logic                 s5_flag;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ui    <= MW'(s4_uni) * MW'($signed({2'b0, s4_inter}));
      s5_bf    <= MW'(s4_bg) * MW'(s4_fu);
      s5_uu    <= MW'(s4_uni) * MW'(s4_uni);
      s5_bb    <= MW'(s4_bg) * MW'(s4_bg);
      s5_uni   <= s4_uni;
      s5_inter <= s4_inter;
      s5_flag  <= s4_flag;
    end
  end

  // stage 6: numerator, denominator, clamp classification
  logic signed [MW-1:0] num_c, den_c;
  div_t                 dv [DIV_STEPS+1];
  div_t                 d0_c;

  always_comb begin
    if (unbiased_mode) begin
      num_c = s5_ui + s5_bf;
      den_c = s5_uu + s5_bb;
    end else begin
      num_c = MW'($signed({2'b0, s5_inter}));
      den_c = MW'(s5_uni);
    end
    d0_c       = '0;
    d0_c.r     = num_c;
    d0_c.d     = den_c;
    d0_c.flag  = s5_flag;
    d0_c.zero  = s5_flag || (num_c <= 64'sd0);
    d0_c.one   = !d0_c.zero && (num_c >= den_c);
    d0_c.inter = s5_inter;
  end

  // divider: one quotient bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= d0_c;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv[k+1] <= div_step(dv[k]);
      end
    end
  end

  always_comb begin
    priority if (dv[DIV_STEPS].zero) begin
      accuracy = '0;
    end else if (dv[DIV_STEPS].one) begin
      accuracy = ACC_ONE;
    end else begin
      accuracy = {1'b0, dv[DIV_STEPS].q};
    end
    overlap_area    = (dv[DIV_STEPS].inter > IW'(AREA_MAX)) ? AREA_MAX
                                                           : dv[DIV_STEPS].inter[FW-1:0];
    undefined_ratio = dv[DIV_STEPS].flag;
  end

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> accuracy <= ACC_ONE)
    else $error("accuracy above one");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && undefined_ratio) |-> accuracy == '0)
    else $error("undefined ratio with nonzero accuracy");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[NSTG-2] && !adv) |=> vld[NSTG-2])
    else $error("beat lost in pipeline stall");

endmodule
